// File: rtl/sbmt_pkg.sv
// shared constants, command codes and aes helper functions for the beacon tracker
package sbmt_pkg;

    localparam int NUM_BEACONS = 8;
    localparam int IDX_W = 3;
    localparam logic [31:0] COUNTER_RESET = 32'h7c84_5f92;
    localparam logic [7:0] NONCE_FILL = 8'haa;

    typedef enum logic [3:0] {
        CMD_WR_ADDR      = 4'd0,
        CMD_WR_UUID      = 4'd1,
        CMD_WR_KEY       = 4'd2,
        CMD_WR_TIMEOUT   = 4'd3,
        CMD_WR_ENABLE    = 4'd4,
        CMD_CLEAR        = 4'd5,
        CMD_LOOKUP       = 4'd6,
        CMD_CHECK_LAST   = 4'd7,
        CMD_MATCH_UUID   = 4'd8,
        CMD_STORE_LAST   = 4'd9,
        CMD_STAMP        = 4'd10,
        CMD_SET_CONN     = 4'd11,
        CMD_CHECK_TMO    = 4'd12
    } cmd_t;

    // aes forward s-box
    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a 128-bit block, byte 0 in the top bits
    function automatic logic [7:0] blk_byte(input logic [127:0] b, input int i);
        return b[127 - 8*i -: 8];
    endfunction

    // one encryption round: subbytes, shiftrows, optional mixcolumns
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic mix);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] o;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[c*4+r] = sbox(blk_byte(s, ((c + r) % 4) * 4 + r));
            end
        end
        if (mix) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
                al = a0 ^ a1 ^ a2 ^ a3;
                t[c*4]   = a0 ^ al ^ xtime(a0 ^ a1);
                t[c*4+1] = a1 ^ al ^ xtime(a1 ^ a2);
                t[c*4+2] = a2 ^ al ^ xtime(a2 ^ a3);
                t[c*4+3] = a3 ^ al ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) begin
            o[127 - 8*i -: 8] = t[i];
        end
        return o;
    endfunction

    // next round key from the previous one
    function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rcon);
        logic [31:0] w0, w1, w2, w3, g;
        w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
        g = {sbox(w3[23:16]) ^ rcon, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ g;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

// File: rtl/sbmt_aes_core.sv
// iterative aes-128 encryption core, one round per cycle with on-the-fly key schedule
module sbmt_aes_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [127:0] key,
    input  logic [127:0] block_in,
    output logic         done,
    output logic [127:0] block_out
);

    logic [127:0] state_reg, state_next;
    logic [127:0] rkey_reg, rkey_next;
    logic [7:0]   rcon_reg, rcon_next;
    logic [3:0]   round_reg, round_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [127:0] nkey;

    assign nkey = sbmt_pkg::key_step(rkey_reg, rcon_reg);

    // round sequencer
    always_comb begin
        state_next = state_reg;
        rkey_next  = rkey_reg;
        rcon_next  = rcon_reg;
        round_next = round_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start) begin
            state_next = block_in ^ key;
            rkey_next  = key;
            rcon_next  = 8'h01;
            round_next = 4'd1;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            state_next = sbmt_pkg::aes_round(state_reg, round_reg != 4'd10) ^ nkey;
            rkey_next  = nkey;
            rcon_next  = sbmt_pkg::xtime(rcon_reg);
            round_next = round_reg + 4'd1;
            if (round_reg == 4'd10) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        state_reg <= state_next;
        rkey_reg  <= rkey_next;
        rcon_reg  <= rcon_next;
        round_reg <= round_next;
    end

    assign done      = done_reg;
    assign block_out = state_reg;

endmodule

// File: rtl/secure_beacon_match_tracker.sv
// beacon tracker top level: entry memory, command sequencer and result register
// match_uuid runs through the aes core, one aes round per cycle
// one command at a time; a new transfer is taken as soon as the sequencer is idle,
// while the previous result may still wait in the output register; table walks
// pass through read, exec and walk for each entry
// reset: synchronous active-low aresetn clears the valid bits, flags and presence;
// counter_base returns to 0x7c845f92; clear works via the valid bits
module secure_beacon_match_tracker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_cmd,
    input  logic [2:0]  s_entry_index,
    input  logic [63:0] s_data_high,
    input  logic [63:0] s_data_low,
    input  logic [31:0] s_counter_tick,
    input  logic [23:0] s_now_ticks,
    input  logic        s_flag_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_found_index,
    output logic        m_matched,
    output logic        m_connect_event,
    output logic        m_disconnect_event,
    output logic        m_presence
);

    localparam int N = sbmt_pkg::NUM_BEACONS;
    localparam int IW = sbmt_pkg::IDX_W;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_READ = 6'b000010,
        ST_EXEC = 6'b000100,
        ST_WALK = 6'b001000,
        ST_AES  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    // one memory row holds all wide fields of an entry
    typedef struct packed {
        logic [47:0]  addr;
        logic [127:0] uuid;
        logic [127:0] key;
        logic [127:0] last;
        logic [23:0]  tmo;
        logic [23:0]  seen;
    } row_t;

    row_t          mem [N];
    row_t          rd_row;
    logic [N-1:0]  valid_reg, valid_next;
    logic [N-1:0]  en_reg, en_next;
    logic [N-1:0]  conn_reg, conn_next;
    logic          pres_reg, pres_next;
    logic [31:0]   cbase_reg;
    state_t        st_reg, st_next;

    logic [3:0]    cmd_reg;
    logic [127:0]  data_reg;
    logic [31:0]   tick_reg;
    logic [23:0]   now_reg;
    logic          flag_reg;

    logic [IW:0]   walk_reg, walk_next;
    logic [IW:0]   found_reg, found_next;
    logic          hit_reg, hit_next;

    logic          wr_en;
    logic [IW-1:0] wr_addr, rd_addr;
    row_t          wr_row, cur_row;

    logic          aes_start, aes_done;
    logic [127:0]  aes_blk, aes_out;

    logic          ov_reg, ov_next;
    logic [3:0]    o_found_reg, o_found_next;
    logic          o_match_reg, o_match_next;
    logic          o_con_reg, o_con_next;
    logic          o_dis_reg, o_dis_next;
    logic          res_load;
    logic [3:0]    res_found_reg;
    logic          res_match_reg, res_con_reg, res_dis_reg, res_pres_reg;
    logic [31:0]   ctr;
    logic [23:0]   dt;

    // an entry never written since clear reads as zero
    assign cur_row = valid_reg[walk_reg[IW-1:0]] ? rd_row : '0;

    assign ctr = cbase_reg + tick_reg;
    assign aes_blk = {ctr[7:0], ctr[15:8], ctr[23:16], ctr[31:24],
                      {12{sbmt_pkg::NONCE_FILL}}};
    assign dt = now_reg - cur_row.seen;

    sbmt_aes_core u_aes (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (aes_start),
        .key       (cur_row.key),
        .block_in  (aes_blk),
        .done      (aes_done),
        .block_out (aes_out)
    );

    // entry memory with registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_row;
        end
        rd_row <= mem[rd_addr];
    end

    assign s_ready = (st_reg == ST_IDLE);

    // command sequencer
    always_comb begin
        st_next      = st_reg;
        valid_next   = valid_reg;
        en_next      = en_reg;
        conn_next    = conn_reg;
        pres_next    = pres_reg;
        walk_next    = walk_reg;
        found_next   = found_reg;
        hit_next     = hit_reg;
        wr_en        = 1'b0;
        wr_addr      = walk_reg[IW-1:0];
        wr_row       = cur_row;
        rd_addr      = walk_reg[IW-1:0];
        aes_start    = 1'b0;
        ov_next      = ov_reg;
        res_load     = 1'b0;
        o_found_next = o_found_reg;
        o_match_next = o_match_reg;
        o_con_next   = o_con_reg;
        o_dis_next   = o_dis_reg;
        if (ov_reg && m_ready) begin
            ov_next = 1'b0;
        end
        case (st_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    walk_next  = (s_cmd == sbmt_pkg::CMD_LOOKUP ||
                                  s_cmd == sbmt_pkg::CMD_CHECK_TMO)
                                 ? '0 : {1'b0, s_entry_index};
                    rd_addr    = (s_cmd == sbmt_pkg::CMD_LOOKUP ||
                                  s_cmd == sbmt_pkg::CMD_CHECK_TMO)
                                 ? '0 : s_entry_index;
                    found_next = (IW+1)'(N);
                    hit_next   = 1'b0;
                    st_next    = ST_READ;
                end
            end
            ST_READ: begin
                st_next = ST_EXEC;
            end
            ST_EXEC: begin
                o_found_next = '0;
                o_match_next = 1'b0;
                o_con_next   = 1'b0;
                o_dis_next   = 1'b0;
                st_next      = ST_OUT;
                case (cmd_reg)
                    sbmt_pkg::CMD_WR_ADDR: begin
                        wr_en = 1'b1; wr_row.addr = data_reg[47:0];
                        valid_next[walk_reg[IW-1:0]] = 1'b1;
                    end
                    sbmt_pkg::CMD_WR_UUID: begin
                        wr_en = 1'b1; wr_row.uuid = data_reg;
                        valid_next[walk_reg[IW-1:0]] = 1'b1;
                    end
                    sbmt_pkg::CMD_WR_KEY: begin
                        wr_en = 1'b1; wr_row.key = data_reg;
                        valid_next[walk_reg[IW-1:0]] = 1'b1;
                    end
                    sbmt_pkg::CMD_WR_TIMEOUT: begin
                        wr_en = 1'b1; wr_row.tmo = data_reg[23:0];
                        valid_next[walk_reg[IW-1:0]] = 1'b1;
                    end
                    sbmt_pkg::CMD_STORE_LAST: begin
                        wr_en = 1'b1; wr_row.last = data_reg;
                        valid_next[walk_reg[IW-1:0]] = 1'b1;
                    end
                    sbmt_pkg::CMD_STAMP: begin
                        wr_en = 1'b1; wr_row.seen = now_reg;
                        valid_next[walk_reg[IW-1:0]] = 1'b1;
                    end
                    sbmt_pkg::CMD_WR_ENABLE: begin
                        en_next[walk_reg[IW-1:0]] = flag_reg;
                    end
                    sbmt_pkg::CMD_CLEAR: begin
                        valid_next = '0; en_next = '0; conn_next = '0; pres_next = 1'b0;
                    end
                    sbmt_pkg::CMD_CHECK_LAST: begin
                        o_match_next = (cur_row.last == data_reg);
                    end
                    sbmt_pkg::CMD_SET_CONN: begin
                        conn_next[walk_reg[IW-1:0]] = 1'b1;
                        if (!pres_reg) begin
                            pres_next = 1'b1; o_con_next = 1'b1;
                        end
                    end
                    sbmt_pkg::CMD_MATCH_UUID: begin
                        aes_start = 1'b1;
                        st_next   = ST_AES;
                    end
                    sbmt_pkg::CMD_LOOKUP, sbmt_pkg::CMD_CHECK_TMO: begin
                        st_next = ST_WALK;
                    end
                    default: begin
                    end
                endcase
                if (cmd_reg == sbmt_pkg::CMD_LOOKUP || cmd_reg == sbmt_pkg::CMD_CHECK_TMO) begin
                    // first entry is already read; fall through to the walk logic
                    st_next = ST_WALK;
                end
            end
            ST_WALK: begin
                // cur_row holds entry walk_reg
                if (cmd_reg == sbmt_pkg::CMD_LOOKUP) begin
                    if (!hit_reg && cur_row.addr == data_reg[47:0]) begin
                        hit_next   = 1'b1;
                        found_next = walk_reg;
                    end
                end else if (dt > cur_row.tmo) begin
                    conn_next[walk_reg[IW-1:0]] = 1'b0;
                end
                if (walk_reg == (IW+1)'(N - 1)) begin
                    st_next = ST_OUT;
                    if (cmd_reg == sbmt_pkg::CMD_LOOKUP) begin
                        o_found_next = (!hit_reg && cur_row.addr == data_reg[47:0])
                                       ? walk_reg : found_reg;
                    end else if (((en_reg & conn_next) == '0) && pres_reg) begin
                        pres_next  = 1'b0;
                        o_dis_next = 1'b1;
                    end
                end else begin
                    walk_next = walk_reg + (IW+1)'(1);
                    rd_addr   = walk_next[IW-1:0];
                    st_next   = ST_READ;
                end
            end
            ST_AES: begin
                if (aes_done) begin
                    o_match_next = ((data_reg ^ aes_out) == cur_row.uuid);
                    st_next      = ST_OUT;
                end
            end
            ST_OUT: begin
                // move the result into the output register once it is free
                if (!ov_reg || m_ready) begin
                    ov_next  = 1'b1;
                    res_load = 1'b1;
                    st_next  = ST_IDLE;
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= ST_IDLE;
            valid_reg <= '0;
            en_reg    <= '0;
            conn_reg  <= '0;
            pres_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            cbase_reg <= sbmt_pkg::COUNTER_RESET;
        end else begin
            st_reg    <= st_next;
            valid_reg <= valid_next;
            en_reg    <= en_next;
            conn_reg  <= conn_next;
            pres_reg  <= pres_next;
            ov_reg    <= ov_next;
            if (cfg_we) begin
                cbase_reg <= cfg_wdata;
            end
        end
        walk_reg    <= walk_next;
        found_reg   <= found_next;
        hit_reg     <= hit_next;
        o_found_reg <= o_found_next;
        o_match_reg <= o_match_next;
        o_con_reg   <= o_con_next;
        o_dis_reg   <= o_dis_next;
        // output register, held while the result waits
        if (res_load) begin
            res_found_reg <= o_found_reg;
            res_match_reg <= o_match_reg;
            res_con_reg   <= o_con_reg;
            res_dis_reg   <= o_dis_reg;
            res_pres_reg  <= pres_reg;
        end
        // capture the command at transfer
        if (s_valid && s_ready) begin
            cmd_reg  <= s_cmd;
            data_reg <= {s_data_high, s_data_low};
            tick_reg <= s_counter_tick;
            now_reg  <= s_now_ticks;
            flag_reg <= s_flag_value;
        end
    end

    assign m_valid            = ov_reg;
    assign m_found_index      = res_found_reg;
    assign m_matched          = res_match_reg;
    assign m_connect_event    = res_con_reg;
    assign m_disconnect_event = res_dis_reg;
    assign m_presence         = res_pres_reg;

endmodule
